// ----- src/uast_pkg.sv -----
// ----------------------------------------------------------------------------
// uast_pkg
// Shared types and constants for the unordered array set table: command
// codes, request and result payloads, controller states, the search token and the cell update.
// ----------------------------------------------------------------------------
package uast_pkg;

	localparam int TableDepth = 16;
	localparam int ValueW     = 32;
	localparam int SlotW      = 4;
	localparam int CountW     = 5;

	typedef enum logic [1:0] {
		CMD_INSERT        = 2'd0,
		CMD_FIND          = 2'd1,
		CMD_SWAP_REMOVE   = 2'd2,
		CMD_STABLE_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [ValueW-1:0] value;
	} req_t;

	typedef struct packed {
		logic              success;
		logic [SlotW-1:0]  slot;
		logic [CountW-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic                     active;
		cmd_t                     command;
		logic                     found;
		logic signed [ValueW-1:0] key;
		logic signed [ValueW-1:0] tail;
	} tok_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [ValueW-1:0] data;
	} upd_t;

endpackage

// ----- src/unordered_array_set_table_core.sv -----
// ----------------------------------------------------------------------------
// unordered_array_set_table_core
// Fixed-capacity table of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// Insert completes at acceptance: the request is accepted and its result is
// registered at the same edge. Find, swap remove and stable remove send a
// search token down the cell row, one cell per cycle over the full depth;
// the result is then settled and the table written once the result register
// is free. One request is in work at a time; the next is accepted once the
// result register is free or being drained.
// ----------------------------------------------------------------------------
module unordered_array_set_table_core #(
	parameter int TABLE_DEPTH = uast_pkg::TableDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  uast_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output uast_pkg::rsp_t rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	uast_pkg::state_t state_q, state_n;
	logic [CW-1:0]    count_q, count_n;
	uast_pkg::rsp_t   rsp_q, rsp_n;
	logic             rsp_valid_q;
	logic             rsp_load;
	logic             rsp_free;
	logic             accept;
	logic             full;
	uast_pkg::tok_t   inj_tok;
	uast_pkg::tok_t   done_tok_q;
	logic [IW-1:0]    done_hit_q;
	uast_pkg::upd_t   upd;
	logic [IW-1:0]    upd_idx;
	logic [IW+3:0]    slot_ext;
	logic [CW+4:0]    cnt_ext;

	uast_pkg::tok_t                     tok   [TABLE_DEPTH];
	logic [IW-1:0]                      hit   [TABLE_DEPTH];
	logic signed [uast_pkg::ValueW-1:0] entry [TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		uast_pkg::tok_t                     tok_in;
		logic [IW-1:0]                      hit_in;
		logic signed [uast_pkg::ValueW-1:0] nxt;
		if (i == 0) begin : g_head
			assign tok_in = inj_tok;
			assign hit_in = '0;
		end else begin : g_body
			assign tok_in = tok[i-1];
			assign hit_in = hit[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nxt = entry[i];
		end else begin : g_mid
			assign nxt = entry[i+1];
		end
		uast_cell #(
			.DEPTH (TABLE_DEPTH),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.tok_i     (tok_in),
			.hit_i     (hit_in),
			.tok_o     (tok[i]),
			.hit_o     (hit[i]),
			.upd       (upd),
			.upd_idx   (upd_idx),
			.nxt_entry (nxt),
			.entry     (entry[i])
		);
	end

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == uast_pkg::ST_IDLE) && rsp_free;
	assign accept    = req_valid && req_ready;
	assign full      = count_q == CW'(TABLE_DEPTH);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			uast_pkg::ST_IDLE: begin
				if (accept && req.command != uast_pkg::CMD_INSERT) state_n = uast_pkg::ST_WALK;
			end
			uast_pkg::ST_WALK: begin
				if (tok[TABLE_DEPTH-1].active) state_n = uast_pkg::ST_DONE;
			end
			uast_pkg::ST_DONE: begin
				if (rsp_free) state_n = uast_pkg::ST_IDLE;
			end
			default: state_n = uast_pkg::ST_IDLE;
		endcase
	end

	// outputs and table updates
	always_comb begin
		inj_tok         = '0;
		inj_tok.command = req.command;
		inj_tok.key     = req.value;
		upd             = '0;
		upd_idx         = '0;
		count_n         = count_q;
		rsp_load        = 1'b0;
		rsp_n           = '0;
		slot_ext        = '0;
		case (state_q)
			uast_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.command == uast_pkg::CMD_INSERT) begin
						rsp_load = 1'b1;
						if (!full) begin
							upd.op   = uast_pkg::OP_LOAD;
							upd.data = req.value;
							upd_idx  = count_q[IW-1:0];
							slot_ext = {4'b0, count_q[IW-1:0]};
							count_n  = count_q + CW'(1);
						end
						rsp_n.success = !full;
					end else begin
						inj_tok.active = 1'b1;
					end
				end
			end
			uast_pkg::ST_DONE: begin
				if (rsp_free) begin
					rsp_load      = 1'b1;
					rsp_n.success = done_tok_q.found;
					if (done_tok_q.found) begin
						slot_ext = {4'b0, done_hit_q};
						upd_idx  = done_hit_q;
						case (done_tok_q.command)
							uast_pkg::CMD_SWAP_REMOVE: begin
								upd.op   = uast_pkg::OP_LOAD;
								upd.data = done_tok_q.tail;
								count_n  = count_q - CW'(1);
							end
							uast_pkg::CMD_STABLE_REMOVE: begin
								upd.op  = uast_pkg::OP_SHIFT;
								count_n = count_q - CW'(1);
							end
							default: begin
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
		cnt_ext           = {5'b0, count_n};
		rsp_n.slot        = slot_ext[3:0];
		rsp_n.entry_count = cnt_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uast_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_n;
		if (state_q == uast_pkg::ST_WALK && tok[TABLE_DEPTH-1].active) begin
			done_tok_q <= tok[TABLE_DEPTH-1];
			done_hit_q <= hit[TABLE_DEPTH-1];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_token_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_DEPTH-1].active |-> state_q == uast_pkg::ST_WALK)
		else $error("search token left the row outside a walk");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == uast_pkg::CMD_INSERT && !full
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(accept) || $past(state_q == uast_pkg::ST_DONE))
		else $error("result raised without a finished request");

endmodule

// ----- src/uast_cell.sv -----
// ----------------------------------------------------------------------------
// uast_cell
// One slot of the table. Holds one entry, checks the passing search token
// against it and hands the token to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module uast_cell #(
	parameter int DEPTH = uast_pkg::TableDepth,
	parameter int INDEX = 0,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [CW-1:0]                      count,
	input  uast_pkg::tok_t                     tok_i,
	input  logic [IW-1:0]                      hit_i,
	output uast_pkg::tok_t                     tok_o,
	output logic [IW-1:0]                      hit_o,
	input  uast_pkg::upd_t                     upd,
	input  logic [IW-1:0]                      upd_idx,
	input  logic signed [uast_pkg::ValueW-1:0] nxt_entry,
	output logic signed [uast_pkg::ValueW-1:0] entry
);

	logic signed [uast_pkg::ValueW-1:0] entry_q;
	uast_pkg::tok_t                     tok_q, tok_n;
	logic [IW-1:0]                      hit_q, hit_n;
	logic                               live;

	assign live = CW'(INDEX) < count;

	always_comb begin
		tok_n = tok_i;
		hit_n = hit_i;
		if (tok_i.active && !tok_i.found && live && entry_q == tok_i.key) begin
			tok_n.found = 1'b1;
			hit_n       = IW'(INDEX);
		end
		if (CW'(INDEX + 1) == count) begin
			tok_n.tail = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_n;
		case (upd.op)
			uast_pkg::OP_LOAD: begin
				if (upd_idx == IW'(INDEX)) entry_q <= upd.data;
			end
			uast_pkg::OP_SHIFT: begin
				if (IW'(INDEX) >= upd_idx) entry_q <= nxt_entry;
			end
			default: begin
			end
		endcase
	end

	assign tok_o = tok_q;
	assign hit_o = hit_q;
	assign entry = entry_q;

endmodule
